// ----- sv/dee_pkg.sv -----
// Package for the delta escape encoder: shared widths, register indices,
// code word and configuration types, and the low-bit mask helper.
// No dependencies.
`timescale 1ns / 1ps

package dee_pkg;

  localparam int SAMPLE_W   = 64;
  localparam int DIM_W      = 2;
  localparam int MAX_DIMS   = 4;
  localparam int DELTA_W    = 6;
  localparam int RAW_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [DELTA_W-1:0] DELTA_MIN   = 6'd2;
  localparam logic [DELTA_W-1:0] DELTA_MAX   = 6'd48;
  localparam logic [DELTA_W-1:0] DELTA_RESET = 6'd8;
  localparam logic [RAW_W-1:0]   RAW_MIN     = 7'd1;
  localparam logic [RAW_W-1:0]   RAW_MAX     = 7'd64;
  localparam logic [RAW_W-1:0]   RAW_RESET   = 7'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA_0 = 3'd0,
    CFG_DELTA_1 = 3'd1,
    CFG_DELTA_2 = 3'd2,
    CFG_DELTA_3 = 3'd3,
    CFG_RAW_0   = 3'd4,
    CFG_RAW_1   = 3'd5,
    CFG_RAW_2   = 3'd6,
    CFG_RAW_3   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MAX_DIMS-1:0][DELTA_W-1:0] delta_w;
    logic [MAX_DIMS-1:0][RAW_W-1:0]   raw_w;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]    dim;
    logic [SAMPLE_W-1:0] sample;
    logic                vend;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [RAW_W-1:0]    width;
    logic                esc;
    logic                last;
  } code_word_t;

  // Status of the result buffer as seen by the input side.
  typedef struct packed {
    logic [1:0] free;
  } outq_status_t;

  // Mask with the low 'bits' bits set; 64 or more gives all ones.
  function automatic logic [SAMPLE_W-1:0] low_mask(input logic [RAW_W-1:0] bits);
    logic [SAMPLE_W-1:0] m;
    if (bits >= RAW_W'(SAMPLE_W)) begin
      m = '1;
    end else begin
      m = (SAMPLE_W'(1) << bits) - SAMPLE_W'(1);
    end
    return m;
  endfunction

endpackage

// ----- sv/dee_cfg.sv -----
// Configuration register file of the delta escape encoder.
// Depends on dee_pkg.
`timescale 1ns / 1ps

module dee_cfg
  import dee_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cfg_r.delta_w[i] <= DELTA_RESET;
        cfg_r.raw_w[i]   <= RAW_RESET;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DELTA_0: cfg_r.delta_w[0] <= cfg_wdata[DELTA_W-1:0];
        CFG_DELTA_1: cfg_r.delta_w[1] <= cfg_wdata[DELTA_W-1:0];
        CFG_DELTA_2: cfg_r.delta_w[2] <= cfg_wdata[DELTA_W-1:0];
        CFG_DELTA_3: cfg_r.delta_w[3] <= cfg_wdata[DELTA_W-1:0];
        CFG_RAW_0:   cfg_r.raw_w[0]   <= cfg_wdata[RAW_W-1:0];
        CFG_RAW_1:   cfg_r.raw_w[1]   <= cfg_wdata[RAW_W-1:0];
        CFG_RAW_2:   cfg_r.raw_w[2]   <= cfg_wdata[RAW_W-1:0];
        CFG_RAW_3:   cfg_r.raw_w[3]   <= cfg_wdata[RAW_W-1:0];
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/dee_encode.sv -----
// Combinational encoder: difference, range check and code word formation
// for one registered sample. Depends on dee_pkg.
`timescale 1ns / 1ps

module dee_encode
  import dee_pkg::*;
(
  input  item_t               item,
  input  logic [SAMPLE_W-1:0] prev,
  input  logic                first_pending,
  input  cfg_t                cfg,
  output code_word_t          word0,
  output code_word_t          word1,
  output logic                escape
);

  logic [DELTA_W-1:0]  k_sel;
  logic [DELTA_W-1:0]  k;
  logic [RAW_W-1:0]    r_sel;
  logic [RAW_W-1:0]    r;
  logic [SAMPLE_W-1:0] half;
  logic [SAMPLE_W-1:0] lim;
  logic [SAMPLE_W-1:0] diff;
  logic                ovf;
  logic                out_of_range;

  always_comb begin
    k_sel = cfg.delta_w[item.dim];
    r_sel = cfg.raw_w[item.dim];
    if (k_sel < DELTA_MIN) begin
      k = DELTA_MIN;
    end else if (k_sel > DELTA_MAX) begin
      k = DELTA_MAX;
    end else begin
      k = k_sel;
    end
    if (r_sel < RAW_MIN) begin
      r = RAW_MIN;
    end else if (r_sel > RAW_MAX) begin
      r = RAW_MAX;
    end else begin
      r = r_sel;
    end

    half = SAMPLE_W'(1) << (k - DELTA_W'(1));
    lim  = half - SAMPLE_W'(1);
    diff = item.sample - prev;
    // Signed overflow of the subtraction means the true difference is huge.
    ovf  = ((item.sample ^ prev) & (item.sample ^ diff)) >> (SAMPLE_W - 1) != '0;
    // Accepts -lim..lim; the marker code -half is therefore escaped too.
    out_of_range = (diff + lim) > (lim << 1);
    escape = first_pending | ovf | out_of_range;

    word1.value = item.sample & low_mask(r);
    word1.width = r;
    word1.esc   = 1'b0;
    word1.last  = 1'b1;

    if (escape) begin
      word0.value = half;
      word0.width = {1'b0, k};
      word0.esc   = 1'b1;
      word0.last  = 1'b0;
    end else begin
      word0.value = diff & low_mask({1'b0, k});
      word0.width = {1'b0, k};
      word0.esc   = 1'b0;
      word0.last  = 1'b1;
    end
  end

endmodule

// ----- sv/dee_outq.sv -----
// Two-word result buffer: takes zero, one or two code words per cycle and
// presents them one at a time on the result channel. Depends on dee_pkg.
`timescale 1ns / 1ps

module dee_outq
  import dee_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   push_cnt,
  input  code_word_t   push0,
  input  code_word_t   push1,
  input  logic         out_stall,
  output logic         out_valid,
  output code_word_t   head,
  output outq_status_t status
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_rem;
  logic       pop;
  code_word_t slot0_r, slot0_nxt;
  code_word_t slot1_r, slot1_nxt;
  code_word_t rem0;

  assign pop     = (cnt_r != 2'd0) && !out_stall;
  assign cnt_rem = cnt_r - {1'b0, pop};
  assign rem0    = pop ? slot1_r : slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case (cnt_rem)
      2'd0: begin
        slot0_nxt = push0;
        slot1_nxt = push1;
      end
      2'd1: begin
        slot0_nxt = rem0;
        slot1_nxt = push0;
      end
      default: begin
        slot0_nxt = slot0_r;
        slot1_nxt = slot1_r;
      end
    endcase
    cnt_nxt = cnt_rem + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid   = cnt_r != 2'd0;
  assign head        = slot0_r;
  assign status.free = 2'd2 - cnt_rem;

endmodule

// ----- sv/delta_escape_encoder.sv -----
// Top level of the delta escape encoder: input register, per-dimension
// history, encoder and result buffer. Depends on dee_pkg, dee_cfg,
// dee_encode and dee_outq.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------
//  in_      | input     | in_valid / in_stall | dimension, sample, vector_end
//  out_     | output    | out_valid/out_stall | code_value, code_width, is_escape,
//           |           |                     | last_word
//  cfg_     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// An item is registered on transfer, encoded in the following cycle and its
// one or two code words are written into a two-word result buffer, which
// presents them on the result port. One item is taken per cycle while
// deltas fit and the result side does not stall; an item that escapes
// occupies the result port with two words, which limits throughput then.
// Reset is synchronous and active low; it restores the register defaults
// and marks the first vector as pending. Stalls on the result side back up
// through the buffer to in_stall, which is high only while the input
// register holds an item that cannot yet move on.

module delta_escape_encoder
  import dee_pkg::*;
#(
  parameter int NUM_DIMS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DIM_W-1:0]      in_dimension,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                  in_vector_end,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_code_value,
  output logic [RAW_W-1:0]      out_code_width,
  output logic                  out_is_escape,
  output logic                  out_last_word,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

  cfg_t         cfg;
  item_t        s1_item_r;
  logic         s1_valid_r, s1_valid_nxt;
  logic         first_pending_r, first_pending_nxt;
  logic [SAMPLE_W-1:0] prev_sample_r [NUM_DIMS];
  logic [IDX_W-1:0]    s1_idx;
  logic         dim_ok;
  logic         escape;
  logic [1:0]   need;
  logic         move;
  logic         load;
  code_word_t   word0, word1, head;
  outq_status_t q_status;

  dee_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register. It refills in the same cycle that its item moves on.
  assign load         = in_valid && !in_stall;
  assign s1_valid_nxt = load || (s1_valid_r && !move);
  assign in_stall     = s1_valid_r && !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r.dim    <= in_dimension;
      s1_item_r.sample <= in_sample;
      s1_item_r.vend   <= in_vector_end;
    end
  end

  // Items for a dimension beyond the configured count are dropped silently.
  assign dim_ok = {1'b0, s1_item_r.dim} < (DIM_W + 1)'(NUM_DIMS);
  assign s1_idx = s1_item_r.dim[IDX_W-1:0];

  dee_encode u_encode (
    .item          (s1_item_r),
    .prev          (prev_sample_r[s1_idx]),
    .first_pending (first_pending_r),
    .cfg           (cfg),
    .word0         (word0),
    .word1         (word1),
    .escape        (escape)
  );

  assign need = !dim_ok ? 2'd0 : (escape ? 2'd2 : 2'd1);
  assign move = s1_valid_r && (need <= q_status.free);

  // History and first-vector flag change only when the item is committed to
  // the result buffer, so the next item always sees them up to date.
  assign first_pending_nxt = (move && dim_ok && s1_item_r.vend) ? 1'b0 : first_pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pending_r <= 1'b1;
    end else begin
      first_pending_r <= first_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move && dim_ok) begin
      prev_sample_r[s1_idx] <= s1_item_r.sample;
    end
  end

  dee_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (move ? need : 2'd0),
    .push0     (word0),
    .push1     (word1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .status    (q_status)
  );

  assign out_code_value = head.value;
  assign out_code_width = head.width;
  assign out_is_escape  = head.esc;
  assign out_last_word  = head.last;

  // An escape marker is never the final word of its item.
  a_escape_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_escape && out_last_word))
    else $error("escape marker flagged as last word");

  // The raw word is buffered together with its marker and follows at once.
  a_raw_follows_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_is_escape) |=> (out_valid && !out_is_escape))
    else $error("raw word missing after escape marker");

  // A marker carries a clamped delta width.
  a_escape_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_escape) |->
      (out_code_width >= {1'b0, DELTA_MIN} && out_code_width <= {1'b0, DELTA_MAX}))
    else $error("escape marker width out of range");

  // Back-pressure on the input only ever comes from a held item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

endmodule

// ----- dv/tb_delta_escape_encoder.sv -----
// Self-checking testbench for the delta escape encoder: a directed table,
// then randomised vector streams over several width settings, checked against
// typed-in words or an in-bench encoder model. Depends on dee_pkg and the RTL.
`timescale 1ns / 1ps

module tb_delta_escape_encoder;
  import dee_pkg::*;

  // Cycles without any transfer or register write before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 1500;
  // Length of the deliberate output hold-off that backs the encoder up.
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 119;
  localparam int DIRECTED_A = 13;
  localparam int DIRECTED_ROWS = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DIM_W-1:0]      in_dimension = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                  in_vector_end = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   out_code_value;
  logic [RAW_W-1:0]      out_code_width;
  logic                  out_is_escape;
  logic                  out_last_word;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  delta_escape_encoder #(.NUM_DIMS(MAX_DIMS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_dimension   (in_dimension),
    .in_sample      (in_sample),
    .in_vector_end  (in_vector_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_value (out_code_value),
    .out_code_width (out_code_width),
    .out_is_escape  (out_is_escape),
    .out_last_word  (out_last_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoder model. It keeps its own copy of the width registers, the last
  // sample of every dimension and the first-vector flag, and turns each
  // accepted item into the one or two code words the encoder must emit.
  // ---------------------------------------------------------------------------
  logic [DELTA_W-1:0]  delta_cfg [MAX_DIMS] = '{default: DELTA_RESET};
  logic [RAW_W-1:0]    raw_cfg [MAX_DIMS] = '{default: RAW_RESET};
  logic [SAMPLE_W-1:0] last_sample [MAX_DIMS] = '{default: '0};
  logic                first_vector = 1'b1;

  code_word_t pending_words [$];
  int         mismatches = 0;
  int         words_checked = 0;

  function automatic logic [SAMPLE_W-1:0] width_mask(input int bits);
    return {SAMPLE_W{1'b1}} >> (SAMPLE_W - bits);
  endfunction

  // Out-of-range register values saturate to the nearest meaningful width.
  function automatic int delta_bits(input logic [DIM_W-1:0] dim);
    int k;
    k = int'(delta_cfg[dim]);
    if (k < int'(DELTA_MIN)) k = int'(DELTA_MIN);
    if (k > int'(DELTA_MAX)) k = int'(DELTA_MAX);
    return k;
  endfunction

  function automatic int raw_bits(input logic [DIM_W-1:0] dim);
    int r;
    r = int'(raw_cfg[dim]);
    if (r < int'(RAW_MIN)) r = int'(RAW_MIN);
    if (r > int'(RAW_MAX)) r = int'(RAW_MAX);
    return r;
  endfunction

  function automatic void encode_sample(input logic [DIM_W-1:0] dim,
                                        input logic [SAMPLE_W-1:0] s,
                                        input logic vend,
                                        output int n,
                                        output code_word_t w0,
                                        output code_word_t w1);
    int k;
    int r;
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] wrapped;
    logic [SAMPLE_W-1:0] half;
    logic signed [SAMPLE_W:0] diff;
    logic signed [SAMPLE_W:0] lim;
    logic escape;
    k = delta_bits(dim);
    r = raw_bits(dim);
    prev = last_sample[dim];
    half = SAMPLE_W'(1) << (k - 1);
    lim = $signed({1'b0, half - SAMPLE_W'(1)});
    // The difference is taken one bit wider so that a wrap cannot hide it.
    diff = $signed({s[SAMPLE_W-1], s}) - $signed({prev[SAMPLE_W-1], prev});
    wrapped = s - prev;
    // The most negative code is reserved as the escape marker, so the legal
    // range is symmetric.
    escape = first_vector || (diff > lim) || (diff < -lim);
    last_sample[dim] = s;
    if (vend) first_vector = 1'b0;
    if (escape) begin
      n = 2;
      w0 = '{value: half, width: RAW_W'(k), esc: 1'b1, last: 1'b0};
      w1 = '{value: s & width_mask(r), width: RAW_W'(r), esc: 1'b0, last: 1'b1};
    end else begin
      n = 1;
      w0 = '{value: wrapped & width_mask(k), width: RAW_W'(k), esc: 1'b0,
             last: 1'b1};
      w1 = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every word transferred out is compared field by field
  // with the oldest word still expected.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch at word %0d, %s: got %h, expected %h",
             $time, words_checked, field, got, want);
  endtask

  code_word_t want_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_code_value, '0);
      end else begin
        want_word = pending_words.pop_front();
        if (out_code_value !== want_word.value)
          report_mismatch("code_value", out_code_value, want_word.value);
        if (out_code_width !== want_word.width)
          report_mismatch("code_width", SAMPLE_W'(out_code_width),
                          SAMPLE_W'(want_word.width));
        if (out_is_escape !== want_word.esc)
          report_mismatch("is_escape", SAMPLE_W'(out_is_escape), SAMPLE_W'(want_word.esc));
        if (out_last_word !== want_word.last)
          report_mismatch("last_word", SAMPLE_W'(out_last_word), SAMPLE_W'(want_word.last));
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls on a pattern of its own, segment by segment: free
  // running, random stalls, a periodic pattern or heavy stalling. When the
  // stimulus asks for it, it holds off for a long stretch so that the result
  // buffer fills and the encoder has to stall its input.
  // ---------------------------------------------------------------------------
  int hold_reqs = 0;
  int holds_done = 0;

  initial begin
    int n;
    int period;
    int count;
    forever begin
      n = $urandom_range(5, 40);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_stall <= 1'b0;
            repeat (n) @(posedge clk);
          end
          1: begin
            repeat (n) begin
              out_stall <= ($urandom_range(0, 2) == 0);
              @(posedge clk);
            end
          end
          2: begin
            period = $urandom_range(2, 5);
            count = 0;
            repeat (n) begin
              out_stall <= (count % period == 0);
              count++;
              @(posedge clk);
            end
          end
          default: begin
            repeat (n) begin
              out_stall <= ($urandom_range(0, 3) != 0);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  // The watchdog restarts on every transfer and every register write, so it
  // only fires when the encoder has locked up or lost a word.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog expired with %0d words outstanding",
             $time, pending_words.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length separated by random gaps;
  // in gapless phases every burst follows the last without a pause. Once an
  // item is transferred, the model works out its words. A directed row may
  // give its words explicitly, in which case those are expected instead.
  // ---------------------------------------------------------------------------
  int   burst_left = 0;
  logic gapless = 1'b0;

  task automatic send_item(input logic [DIM_W-1:0] dim, input logic [SAMPLE_W-1:0] s,
                           input logic vend, input logic [1:0] n_typed,
                           input logic [SAMPLE_W-1:0] v0, input logic [RAW_W-1:0] wd0,
                           input logic [SAMPLE_W-1:0] v1, input logic [RAW_W-1:0] wd1);
    int n;
    int gap;
    code_word_t p0;
    code_word_t p1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_dimension  <= dim;
    in_sample     <= s;
    in_vector_end <= vend;
    do @(posedge clk); while (!(in_valid && !in_stall));
    encode_sample(dim, s, vend, n, p0, p1);
    if (n_typed == 0) begin
      pending_words.push_back(p0);
      if (n == 2) pending_words.push_back(p1);
    end else begin
      pending_words.push_back('{value: v0, width: wd0, esc: (n_typed == 2),
                                last: (n_typed == 1)});
      if (n_typed == 2)
        pending_words.push_back('{value: v1, width: wd1, esc: 1'b0, last: 1'b1});
    end
  endtask

  // Stops offering items and waits until every expected word has arrived.
  // Each item gives at least one word, so the encoder is then idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Writes all eight width registers, one per cycle, and mirrors them into
  // the model. Only called while the encoder is idle.
  task automatic program_widths(input logic [CFG_DATA_W-1:0] dsel [MAX_DIMS],
                                input logic [CFG_DATA_W-1:0] rsel [MAX_DIMS]);
    for (int d = 0; d < MAX_DIMS; d++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_idx_t'(CFG_DELTA_0 + d);
      cfg_wdata <= dsel[d];
      @(posedge clk);
      delta_cfg[d] = dsel[d][DELTA_W-1:0];
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_idx_t'(CFG_RAW_0 + d);
      cfg_wdata <= rsel[d];
      @(posedge clk);
      raw_cfg[d] = rsel[d];
    end
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Where the word count is non-zero the expected words are
  // typed in: with two words the first is the escape marker and the second
  // the raw sample; with one word it is the difference code. Rows with a
  // count of zero are checked against the model.
  //
  // The first block runs at the reset widths (delta 8, raw 32). It covers the
  // first vector, which escapes throughout, the largest and smallest legal
  // differences, a difference equal to the escape code, and differences that
  // overflow 64 bits and would look small if wrapped.
  //
  // The second block runs with the width extremes: dimension 0 at delta 2 and
  // raw 1, dimension 1 at delta 48 and raw 64, dimension 2 with zero in both
  // registers (read as 2 and 1) and dimension 3 with the registers at their
  // maxima (read as 48 and 64).
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [DIM_W-1:0]    dim;
    logic [SAMPLE_W-1:0] sample;
    logic                vend;
    logic [1:0]          n;
    logic [SAMPLE_W-1:0] v0;
    logic [RAW_W-1:0]    w0;
    logic [SAMPLE_W-1:0] v1;
    logic [RAW_W-1:0]    w1;
  } stim_row_t;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{2'd0, 64'h0000_0000_0000_0123, 1'b0, 2'd2, 64'h80, 7'd8, 64'h123, 7'd32},
    '{2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd2, 64'h80, 7'd8, 64'hFFFF_FFFF, 7'd32},
    '{2'd2, 64'h8000_0000_0000_0000, 1'b0, 2'd2, 64'h80, 7'd8, 64'h0, 7'd32},
    '{2'd3, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 2'd2, 64'h80, 7'd8, 64'hFFFF_FFFF, 7'd32},
    '{2'd0, 64'h0000_0000_0000_01A2, 1'b0, 2'd1, 64'h7F, 7'd8, 64'h0, 7'd0},
    '{2'd0, 64'h0000_0000_0000_0123, 1'b0, 2'd1, 64'h81, 7'd8, 64'h0, 7'd0},
    '{2'd0, 64'h0000_0000_0000_00A3, 1'b0, 2'd2, 64'h80, 7'd8, 64'hA3, 7'd32},
    '{2'd0, 64'h0000_0000_0000_0123, 1'b0, 2'd2, 64'h80, 7'd8, 64'h123, 7'd32},
    '{2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd1, 64'h0, 7'd8, 64'h0, 7'd0},
    '{2'd2, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 2'd2, 64'h80, 7'd8, 64'hFFFF_FFFF, 7'd32},
    '{2'd3, 64'h8000_0000_0000_0000, 1'b0, 2'd2, 64'h80, 7'd8, 64'h0, 7'd32},
    '{2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd2, 64'h80, 7'd8, 64'hFFFF_FFFF, 7'd32},
    '{2'd3, 64'h8000_0000_0000_0005, 1'b1, 2'd1, 64'h5, 7'd8, 64'h0, 7'd0},
    '{2'd0, 64'h0000_0000_0000_0124, 1'b0, 2'd1, 64'h1, 7'd2, 64'h0, 7'd0},
    '{2'd0, 64'h0000_0000_0000_0123, 1'b0, 2'd1, 64'h3, 7'd2, 64'h0, 7'd0},
    '{2'd0, 64'h0000_0000_0000_0125, 1'b0, 2'd2, 64'h2, 7'd2, 64'h1, 7'd1},
    '{2'd1, 64'h0000_7FFF_FFFF_FFFE, 1'b0, 2'd1, 64'h7FFF_FFFF_FFFF, 7'd48, 64'h0, 7'd0},
    '{2'd1, 64'h0000_FFFF_FFFF_FFFE, 1'b0, 2'd2, 64'h8000_0000_0000, 7'd48,
      64'h0000_FFFF_FFFF_FFFE, 7'd64},
    '{2'd2, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 2'd1, 64'h3, 7'd2, 64'h0, 7'd0},
    '{2'd2, 64'h0000_0000_0000_0001, 1'b0, 2'd2, 64'h2, 7'd2, 64'h1, 7'd1},
    '{2'd3, 64'h8000_8000_0000_0004, 1'b0, 2'd1, 64'h7FFF_FFFF_FFFF, 7'd48, 64'h0, 7'd0},
    '{2'd3, 64'h8000_0000_0000_0004, 1'b0, 2'd2, 64'h8000_0000_0000, 7'd48,
      64'h8000_0000_0000_0004, 7'd64},
    '{2'd1, 64'h0000_7FFF_FFFF_FFFF, 1'b1, 2'd1, 64'h8000_0000_0001, 7'd48, 64'h0, 7'd0},
    '{2'd0, 64'h0F0F_F0F0_1234_5678, 1'b0, 2'd0, 64'h0, 7'd0, 64'h0, 7'd0},
    '{2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2'd0, 64'h0, 7'd0, 64'h0, 7'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] dsel [MAX_DIMS];
    logic [CFG_DATA_W-1:0] rsel [MAX_DIMS];
    logic [DIM_W-1:0]      dim;
    logic                  vend;
    logic [SAMPLE_W-1:0]   s;
    logic [SAMPLE_W-1:0]   prev;
    logic [SAMPLE_W-1:0]   mag;
    logic [SAMPLE_W-1:0]   lim;
    int                    k;
    int                    kind;
    int                    vec_pos;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed block at the reset widths.
    for (int i = 0; i < DIRECTED_A; i++) begin
      send_item(directed_rows[i].dim, directed_rows[i].sample, directed_rows[i].vend,
                directed_rows[i].n, directed_rows[i].v0, directed_rows[i].w0,
                directed_rows[i].v1, directed_rows[i].w1);
    end
    wait_drained();

    // Directed block at the width extremes, including out-of-range settings.
    dsel = '{7'd2, 7'd48, 7'd0, 7'd63};
    rsel = '{7'd1, 7'd64, 7'd0, 7'd127};
    program_widths(dsel, rsel);
    for (int i = DIRECTED_A; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].dim, directed_rows[i].sample, directed_rows[i].vend,
                directed_rows[i].n, directed_rows[i].v0, directed_rows[i].w0,
                directed_rows[i].v1, directed_rows[i].w1);
    end
    wait_drained();

    // Random phases. The first two use uniform extreme widths; the rest mix
    // random register values (upper bits included) with common settings.
    vec_pos = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (phase == 0) begin
          dsel[d] = 7'(DELTA_MIN);
          rsel[d] = 7'(RAW_MIN);
        end else if (phase == 1) begin
          dsel[d] = 7'(DELTA_MAX);
          rsel[d] = 7'(RAW_MAX);
        end else begin
          case ($urandom_range(0, 3))
            0: dsel[d] = 7'($urandom_range(0, 127));
            1: dsel[d] = 7'($urandom_range(2, 12));
            2: dsel[d] = 7'($urandom_range(13, 48));
            default: dsel[d] = ($urandom_range(0, 1) != 0) ? 7'(DELTA_MIN) : 7'(DELTA_MAX);
          endcase
          case ($urandom_range(0, 2))
            0: rsel[d] = 7'($urandom_range(0, 127));
            1: rsel[d] = 7'($urandom_range(1, 64));
            default: rsel[d] = ($urandom_range(0, 1) != 0) ? 7'(RAW_MIN) : 7'(RAW_MAX);
          endcase
        end
      end
      program_widths(dsel, rsel);

      // Some phases offer items back to back; two of them also get the long
      // output hold-off so that the input side is forced to stall.
      gapless = (phase % 3 == 0);
      burst_left = 0;
      if (phase == 3 || phase == 9) hold_reqs++;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Mostly well-formed vectors, dimension 0 up to 3 with the end flag on
        // the last; the rest carry a random dimension and a random end flag.
        if ($urandom_range(0, 99) < 85) begin
          dim = DIM_W'(vec_pos);
          vend = (vec_pos == MAX_DIMS - 1);
          vec_pos = (vec_pos + 1) % MAX_DIMS;
        end else begin
          dim = DIM_W'($urandom_range(0, MAX_DIMS - 1));
          vend = 1'($urandom_range(0, 1));
        end
        prev = last_sample[dim];
        k = delta_bits(dim);
        lim = (SAMPLE_W'(1) << (k - 1)) - SAMPLE_W'(1);
        kind = $urandom_range(0, 9);
        // Differences are drawn mostly around the legal range, with a share
        // sitting exactly on its edges, plus free and extreme samples.
        if (kind <= 4) mag = {$urandom, $urandom} & width_mask($urandom_range(1, k));
        else if (kind <= 6) mag = lim + SAMPLE_W'($urandom_range(0, 1));
        else mag = SAMPLE_W'($urandom_range(0, 1));
        if (kind == 7) begin
          s = {$urandom, $urandom};
        end else if (kind == 8) begin
          case ($urandom_range(0, 3))
            0: s = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            1: s = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            2: s = '0;
            default: s = '1;
          endcase
        end else begin
          s = ($urandom_range(0, 1) != 0) ? prev + mag : prev - mag;
        end
        send_item(dim, s, vend, 2'd0, '0, '0, '0, '0);
      end
      wait_drained();
    end

    // Let any stray word that the encoder might still emit show up.
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
